// File: sv/iut_pkg.sv
// Package for the interval union table: sizes, item codes, cell control and
// interval types. No dependencies; used by iut_cell and interval_union_table_top.
package iut_pkg;

  localparam int CAPACITY  = 16;
  localparam int TIME_W    = 11;
  localparam int OUT_CNT_W = 5;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int LEN_W     = CNT_W + 1;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DUMP   = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] beg;
    logic [TIME_W-1:0] fin;
  } ivl_t;

  typedef struct packed {
    logic shift;
    logic take_head;
    logic load;
  } cell_ctl_t;

  function automatic logic [OUT_CNT_W-1:0] to_out_cnt(input logic [CNT_W-1:0] c);
    logic [CNT_W+OUT_CNT_W-1:0] w;
    w = {{OUT_CNT_W{1'b0}}, c};
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

// File: sv/iut_cell.sv
// One table cell: holds a stored interval and passes it towards the head.
// Depends on iut_pkg.
module iut_cell (
  input  logic              clk_i,
  input  iut_pkg::cell_ctl_t ctl_i,
  input  iut_pkg::ivl_t     nxt_i,
  input  iut_pkg::ivl_t     head_i,
  input  iut_pkg::ivl_t     load_i,
  output iut_pkg::ivl_t     q_o
);

  iut_pkg::ivl_t ivl_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ivl_q <= load_i;
    end else if (ctl_i.shift) begin
      ivl_q <= ctl_i.take_head ? head_i : nxt_i;
    end
  end

  assign q_o = ivl_q;

endmodule

// File: sv/interval_union_table_top.sv
// Top level of the interval union table: control, output register and the
// row of iut_cell instances. Depends on iut_pkg and iut_cell.
//
// Input channel (in_valid_i / in_stall_o): mode_i = 0 inserts the interval
// start_time_i..end_time_i, mode_i = 1 dumps the table. Output channel
// (out_valid_o / out_stall_i) carries the results. An item is taken when
// valid is high and stall is low.
// The table is a row of cells that shifts towards cell 0. An insert rotates
// the n stored entries (n = 0..CAPACITY) past a compare unit at cell 0, one
// per cycle, dropping those it absorbs and re-appending the rest behind, then
// writes the merged interval after the survivors (or drops the new interval
// if the table is full and none was absorbed); either way, one result.
// A dump rotates the table likewise and gives one item per cycle while the
// receiver does not stall, n items (one for an empty table), each registered
// as its entry leaves cell 0. One item is worked on at a time: in_stall_o is
// high from acceptance until its last result sits in the output register.
// When the receiver stalls, the result holds in the output register and a dump
// waits, an insert sweeps on; reset empties the table (count zero) at once,
// with no clearing pass, and drops any pending result.
module interval_union_table_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [iut_pkg::TIME_W-1:0]      start_time_i,
  input  logic [iut_pkg::TIME_W-1:0]      end_time_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [iut_pkg::TIME_W-1:0]      out_start_o,
  output logic [iut_pkg::TIME_W-1:0]      out_end_o,
  output logic [iut_pkg::OUT_CNT_W-1:0]   stored_count_o,
  output logic                            dropped_o,
  output logic                            last_of_run_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic                          state_q, state_d;
  logic                          mode_q, mode_d;
  logic [iut_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [iut_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic [iut_pkg::CNT_W-1:0]     kept_q, kept_d;
  logic                          absorbed_q, absorbed_d;
  iut_pkg::ivl_t                 cur_q, cur_d;
  iut_pkg::ivl_t                 orig_q, orig_d;

  logic                          out_v_q;
  iut_pkg::ivl_t                 out_ivl_q;
  logic [iut_pkg::OUT_CNT_W-1:0] out_cnt_q;
  logic                          out_drop_q, out_last_q;

  logic                          in_acc, out_free;
  logic                          step, keep, load;
  logic                          emit, e_drop, e_last;
  iut_pkg::ivl_t                 e_ivl;
  logic [iut_pkg::OUT_CNT_W-1:0] e_cnt;
  iut_pkg::ivl_t                 head;
  logic                          hit;
  logic [iut_pkg::LEN_W-1:0]     wpos;

  iut_pkg::ivl_t                 cell_q  [iut_pkg::CAPACITY];
  iut_pkg::cell_ctl_t            cell_ctl[iut_pkg::CAPACITY];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_v_q || !out_stall_i;
  assign head       = cell_q[0];
  assign hit        = (head.beg <= cur_q.fin) && (head.fin >= cur_q.beg);
  assign wpos       = {1'b0, rem_q} + {1'b0, kept_q} - iut_pkg::LEN_W'(1);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    kept_d     = kept_q;
    absorbed_d = absorbed_q;
    cur_d      = cur_q;
    orig_d     = orig_q;
    step       = 1'b0;
    keep       = 1'b0;
    load       = 1'b0;
    emit       = 1'b0;
    e_ivl      = head;
    e_cnt      = iut_pkg::to_out_cnt(cnt_q);
    e_drop     = 1'b0;
    e_last     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d    = S_RUN;
          mode_d     = mode_i;
          rem_d      = cnt_q;
          kept_d     = '0;
          absorbed_d = 1'b0;
          cur_d      = '{beg: start_time_i, fin: end_time_i};
          orig_d     = '{beg: start_time_i, fin: end_time_i};
        end
      end
      S_RUN: begin
        if (rem_q != '0) begin
          if (mode_q == iut_pkg::MODE_DUMP) begin
            if (out_free) begin
              step   = 1'b1;
              keep   = 1'b1;
              emit   = 1'b1;
              e_last = (rem_q == iut_pkg::CNT_W'(1));
              rem_d  = rem_q - iut_pkg::CNT_W'(1);
              kept_d = kept_q + iut_pkg::CNT_W'(1);
              if (rem_q == iut_pkg::CNT_W'(1)) begin
                state_d = S_IDLE;
              end
            end
          end else begin
            step  = 1'b1;
            rem_d = rem_q - iut_pkg::CNT_W'(1);
            if (hit) begin
              absorbed_d = 1'b1;
              if (head.beg < cur_q.beg) cur_d.beg = head.beg;
              if (head.fin > cur_q.fin) cur_d.fin = head.fin;
            end else begin
              keep   = 1'b1;
              kept_d = kept_q + iut_pkg::CNT_W'(1);
            end
          end
        end else if (out_free) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = S_IDLE;
          if (mode_q == iut_pkg::MODE_DUMP) begin
            e_ivl = '0;
            e_cnt = '0;
          end else if (!absorbed_q && (cnt_q == iut_pkg::CNT_W'(iut_pkg::CAPACITY))) begin
            e_ivl  = orig_q;
            e_drop = 1'b1;
          end else begin
            load  = 1'b1;
            e_ivl = cur_q;
            cnt_d = kept_q + iut_pkg::CNT_W'(1);
            e_cnt = iut_pkg::to_out_cnt(kept_q + iut_pkg::CNT_W'(1));
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      kept_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      kept_q  <= kept_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    absorbed_q <= absorbed_d;
    cur_q      <= cur_d;
    orig_q     <= orig_d;
    if (emit) begin
      out_ivl_q  <= e_ivl;
      out_cnt_q  <= e_cnt;
      out_drop_q <= e_drop;
      out_last_q <= e_last;
    end
  end

  for (genvar i = 0; i < iut_pkg::CAPACITY; i++) begin : g_cell
    assign cell_ctl[i].shift     = step;
    assign cell_ctl[i].take_head = keep && (wpos == iut_pkg::LEN_W'(i));
    assign cell_ctl[i].load      = load && (kept_q == iut_pkg::CNT_W'(i));

    if (i == iut_pkg::CAPACITY - 1) begin : g_tail
      iut_cell u_cell (
        .clk_i  (clk_i),
        .ctl_i  (cell_ctl[i]),
        .nxt_i  (cell_q[i]),
        .head_i (head),
        .load_i (cur_q),
        .q_o    (cell_q[i])
      );
    end else begin : g_body
      iut_cell u_cell (
        .clk_i  (clk_i),
        .ctl_i  (cell_ctl[i]),
        .nxt_i  (cell_q[i+1]),
        .head_i (head),
        .load_i (cur_q),
        .q_o    (cell_q[i])
      );
    end
  end

  assign out_valid_o    = out_v_q;
  assign out_start_o    = out_ivl_q.beg;
  assign out_end_o      = out_ivl_q.fin;
  assign stored_count_o = out_cnt_q;
  assign dropped_o      = out_drop_q;
  assign last_of_run_o  = out_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= iut_pkg::CNT_W'(iut_pkg::CAPACITY))
    else $error("stored count above capacity");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> ({1'b0, rem_q} + {1'b0, kept_q} <= {1'b0, cnt_q}))
    else $error("queue length exceeds stored count");

  a_accept_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_RUN))
    else $error("accepted item did not start");

  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && rem_q == '0 && out_free) |=> (state_q == S_IDLE && out_v_q))
    else $error("final result not issued");

endmodule

// File: verif/iut_interval_checker.sv
// Checker for the interval union table: watches both item channels, keeps its
// own copy of the interval table, predicts every result and compares in order.
// Depends on iut_pkg; instantiated beside the block by interval_union_table_top_test.
module iut_interval_checker
  import iut_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 mode_i,
  input  logic [TIME_W-1:0]    start_time_i,
  input  logic [TIME_W-1:0]    end_time_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [TIME_W-1:0]    out_start_i,
  input  logic [TIME_W-1:0]    out_end_i,
  input  logic [OUT_CNT_W-1:0] stored_count_i,
  input  logic                 dropped_i,
  input  logic                 last_of_run_i,
  output int                   error_count_o,
  output int                   awaited_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TIME_W-1:0]    beg;
    logic [TIME_W-1:0]    fin;
    logic [OUT_CNT_W-1:0] count;
    logic                 dropped;
    logic                 last;
  } iut_result_t;

  ivl_t        ivl_store[CAPACITY];
  int unsigned held = 0;
  iut_result_t awaited[$];
  iut_result_t want;
  iut_result_t got;
  int          errors = 0;
  int          awaited_n = 0;

  assign error_count_o   = errors;
  assign awaited_count_o = awaited_n;

  function automatic iut_result_t make_result(input logic [TIME_W-1:0] b,
                                              input logic [TIME_W-1:0] f,
                                              input int unsigned cnt,
                                              input logic drop,
                                              input logic last);
    iut_result_t r;
    r.beg     = b;
    r.fin     = f;
    r.count   = OUT_CNT_W'(cnt);
    r.dropped = drop;
    r.last    = last;
    return r;
  endfunction

  task automatic queue_result(input iut_result_t r);
    awaited.insert(awaited.size(), r);
  endtask

  // The new interval widens as it sweeps the table in order; absorbed entries vanish,
  // survivors keep order, the merged one goes last unless a full table absorbs none.
  task automatic merge_into_table(input logic [TIME_W-1:0] b_in,
                                  input logic [TIME_W-1:0] f_in);
    ivl_t              survivors[CAPACITY];
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    int unsigned       kept;
    bit                absorbed;
    lo       = b_in;
    hi       = f_in;
    kept     = 0;
    absorbed = 1'b0;
    for (int k = 0; k < held; k++) begin
      if (ivl_store[k].beg <= hi && ivl_store[k].fin >= lo) begin
        if (ivl_store[k].beg < lo) lo = ivl_store[k].beg;
        if (ivl_store[k].fin > hi) hi = ivl_store[k].fin;
        absorbed = 1'b1;
      end else begin
        survivors[kept] = ivl_store[k];
        kept++;
      end
    end
    if (!absorbed && held >= CAPACITY) begin
      queue_result(make_result(b_in, f_in, held, 1'b1, 1'b1));
    end else begin
      for (int k = 0; k < kept; k++) ivl_store[k] = survivors[k];
      ivl_store[kept].beg = lo;
      ivl_store[kept].fin = hi;
      held = kept + 1;
      queue_result(make_result(lo, hi, held, 1'b0, 1'b1));
    end
  endtask

  task automatic list_table();
    if (held == 0) begin
      queue_result(make_result('0, '0, 0, 1'b0, 1'b1));
    end else begin
      for (int k = 0; k < held; k++)
        queue_result(make_result(ivl_store[k].beg, ivl_store[k].fin, held, 1'b0,
                                 (k + 1 == held)));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      awaited.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == MODE_DUMP) list_table();
        else merge_into_table(start_time_i, end_time_i);
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{out_start_i, out_end_i, stored_count_i, dropped_i, last_of_run_i};
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected item: start %0d end %0d count %0d drop %0b last %0b",
                     $realtime, got.beg, got.fin, got.count, got.dropped, got.last);
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: exp %0d..%0d n %0d d %0b l %0b, got %0d..%0d n %0d d %0b l %0b",
                       $realtime, want.beg, want.fin, want.count, want.dropped,
                       want.last, got.beg, got.fin, got.count, got.dropped, got.last);
          end
        end
      end
    end
    awaited_n = awaited.size();
  end

endmodule

// File: verif/interval_union_table_top_test.sv
// Testbench top for interval_union_table_top: clock, reset, directed and random
// insert/dump items, output stalls and the verdict. Depends on iut_pkg, the block
// and iut_interval_checker.
module interval_union_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import iut_pkg::*;

  localparam int RANDOM_ITEMS   = 120;
  localparam int QUIET_TAIL     = 30;
  localparam int LONG_HOLD      = 250;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 mode_i;
  logic [TIME_W-1:0]    start_time_i;
  logic [TIME_W-1:0]    end_time_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [TIME_W-1:0]    out_start_o;
  logic [TIME_W-1:0]    out_end_o;
  logic [OUT_CNT_W-1:0] stored_count_o;
  logic                 dropped_o;
  logic                 last_of_run_o;

  int errors;
  int awaited_n;
  int stuck_cycles = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int calm_items   = 0;
  bit quiet_tail   = 1'b0;

  interval_union_table_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .start_time_i   (start_time_i),
    .end_time_i     (end_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_start_o    (out_start_o),
    .out_end_o      (out_end_o),
    .stored_count_o (stored_count_o),
    .dropped_o      (dropped_o),
    .last_of_run_o  (last_of_run_o)
  );

  iut_interval_checker result_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .mode_i          (mode_i),
    .start_time_i    (start_time_i),
    .end_time_i      (end_time_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_start_i     (out_start_o),
    .out_end_i       (out_end_o),
    .stored_count_i  (stored_count_o),
    .dropped_i       (dropped_o),
    .last_of_run_i   (last_of_run_o),
    .error_count_o   (errors),
    .awaited_count_o (awaited_n)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stall bursts, calm stretches, and requested long hold-offs.
  initial begin
    int calm;
    calm        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served < holds_asked) begin
        holds_served++;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet_tail) begin
        if (calm > 0) begin
          calm--;
        end else if ($urandom_range(0, 49) == 0) begin
          calm = $urandom_range(20, 60);
        end else if ($urandom_range(0, 5) == 0) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 9)) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic offer(input logic m, input logic [TIME_W-1:0] b, input logic [TIME_W-1:0] f);
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    start_time_i <= b;
    end_time_i   <= f;
    do @(posedge clk_i); while (in_stall_o);
    if (calm_items > 0) begin
      calm_items--;
    end else if ($urandom_range(0, 15) == 0) begin
      calm_items = $urandom_range(5, 15);
    end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_n != 0);
  endtask

  task automatic random_item();
    int unsigned       pick;
    int unsigned       e;
    logic [TIME_W-1:0] b;
    pick = $urandom_range(0, 99);
    b    = TIME_W'($urandom_range(0, 1439));
    if (pick < 12) begin
      offer(MODE_DUMP, TIME_W'($urandom), TIME_W'($urandom));
    end else if (pick < 17) begin
      e = b + $urandom_range(100, 900);
      offer(MODE_INSERT, b, TIME_W'((e > 1439) ? 1439 : e));
    end else if (pick < 23) begin
      offer(MODE_INSERT, TIME_W'($urandom), TIME_W'($urandom));
    end else if (pick < 33) begin
      offer(MODE_INSERT, b, b);
    end else begin
      e = b + $urandom_range(0, 12);
      offer(MODE_INSERT, b, TIME_W'((e > 1439) ? 1439 : e));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = MODE_INSERT;
    start_time_i = '0;
    end_time_i   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer(MODE_DUMP, '0, '0);
    offer(MODE_INSERT, 11'd0, 11'd0);
    offer(MODE_INSERT, 11'd2047, 11'd2047);
    offer(MODE_INSERT, 11'd1439, 11'd1439);
    offer(MODE_INSERT, 11'd1, 11'd1);
    offer(MODE_INSERT, 11'd0, 11'd1);
    offer(MODE_INSERT, 11'd500, 11'd400);
    offer(MODE_INSERT, 11'd400, 11'd500);
    offer(MODE_DUMP, 11'd2047, 11'd2047);
    // overfill with disjoint intervals so that the last ones are dropped
    for (int k = 0; k < CAPACITY; k++)
      offer(MODE_INSERT, TIME_W'(1500 + 30 * k), TIME_W'(1510 + 30 * k));
    offer(MODE_INSERT, 11'd1505, 11'd1505);
    offer(MODE_DUMP, '0, '0);
    offer(MODE_INSERT, 11'd0, 11'd2047);
    offer(MODE_DUMP, '0, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 40) holds_asked++;
      if (i == 90) drain();
      if (i == RANDOM_ITEMS - QUIET_TAIL) quiet_tail = 1'b1;
      random_item();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && awaited_n == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
